FILE: sv/shpp_pkg.sv
// ---------------------------------------------------------------------------
// shpp_pkg: shared types and constants of the shard placement picker
// Holds the strategy and register codes, the record that passes from the
// classifying front end to the selection back end, and sizing constants.
// ---------------------------------------------------------------------------
package shpp_pkg;

  // default depth of the healthy id buffer
  localparam int unsigned MaxShardsDefault = 64;

  // payload widths fixed by the interface
  localparam int unsigned IdW     = 16;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned WeightW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ProdW   = WeightW + CountW;

  // round robin position and the bit index used by the remainder unit
  localparam int unsigned RrW    = 64;
  localparam int unsigned RrBitW = $clog2(RrW);

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [31:0] TimeoutReset = 32'd10000;

  // decoupling queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    STRAT_ROUND_ROBIN = 2'd0,
    STRAT_LEAST_COUNT = 2'd1,
    STRAT_WEIGHTED    = 2'd2
  } strat_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRATEGY = 2'd0,
    CFG_TIMEOUT  = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_L,
    BK_MUL_R,
    BK_CMP,
    BK_END,
    BK_DIV,
    BK_READ,
    BK_RR_OUT
  } back_state_e;

  // classified record handed from front to back
  typedef struct packed {
    logic               healthy;
    logic               last;
    logic [IdW-1:0]     id;
    logic [WeightW-1:0] weight;
    logic [CountW-1:0]  count;
  } rec_t;

endpackage

FILE: sv/shpp_front.sv
// ---------------------------------------------------------------------------
// shpp_front: request intake and health classification
// Checks each incoming shard record against the heartbeat timeout, folds a
// zero weight to one and pushes the classified record into the queue.
// ---------------------------------------------------------------------------
module shpp_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           has_record_i,
  input  logic [shpp_pkg::IdW-1:0]       shard_id_i,
  input  logic                           is_online_i,
  input  logic                           has_heartbeat_i,
  input  logic [shpp_pkg::TimeW-1:0]     heartbeat_ms_i,
  input  logic [shpp_pkg::TimeW-1:0]     now_ms_i,
  input  logic [shpp_pkg::WeightW-1:0]   capacity_weight_i,
  input  logic [shpp_pkg::CountW-1:0]    graph_count_i,
  input  logic                           last_i,
  input  logic [31:0]                    timeout_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output shpp_pkg::rec_t                 push_data_o
);

  logic [shpp_pkg::TimeW-1:0] age;
  logic                       fresh;

  // heartbeat age check, a heartbeat in the future counts as fresh
  assign age   = now_ms_i - heartbeat_ms_i;
  assign fresh = (now_ms_i < heartbeat_ms_i) ||
                 (age <= {{(shpp_pkg::TimeW-32){1'b0}}, timeout_i});

  // build the classified record
  always_comb begin
    push_data_o.healthy = has_record_i && is_online_i && has_heartbeat_i && fresh;
    push_data_o.last    = last_i;
    push_data_o.id      = shard_id_i;
    push_data_o.weight  = (capacity_weight_i == '0) ? shpp_pkg::WeightW'(1)
                                                   : capacity_weight_i;
    push_data_o.count   = graph_count_i;
  end

  // request handshake
  assign push_valid_o = in_valid_i;
  assign in_stall_o   = !push_ready_i;

endmodule

FILE: sv/shpp_queue.sv
// ---------------------------------------------------------------------------
// shpp_queue: short record queue between front and back
// A small register queue so the intake and the selection logic can stall
// independently of each other.
// ---------------------------------------------------------------------------
module shpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  shpp_pkg::rec_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output shpp_pkg::rec_t pop_data_o
);

  localparam int unsigned Depth = shpp_pkg::QueueDepth;
  localparam int unsigned PtrW  = shpp_pkg::QueuePtrW;
  localparam int unsigned CntW  = shpp_pkg::QueueCntW;

  shpp_pkg::rec_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            push, pop;

  assign push_ready_o = (fill_q != CntW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/shpp_back.sv
// ---------------------------------------------------------------------------
// shpp_back: candidate tracking and result selection
// Buffers healthy ids, tracks the least count and weighted candidates with
// one shared multiplier, and on the final record of a request picks the
// result; round robin uses a bit serial remainder unit.
// ---------------------------------------------------------------------------
module shpp_back #(
  parameter int unsigned MaxShards = shpp_pkg::MaxShardsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  strategy_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  shpp_pkg::rec_t              pop_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [shpp_pkg::IdW-1:0]    chosen_shard_o,
  output logic                        overflow_o
);

  localparam int unsigned CntW  = $clog2(MaxShards + 1);
  localparam int unsigned AddrW = (MaxShards > 1) ? $clog2(MaxShards) : 1;
  localparam int unsigned IdW   = shpp_pkg::IdW;
  localparam int unsigned WW    = shpp_pkg::WeightW;
  localparam int unsigned NW    = shpp_pkg::CountW;
  localparam int unsigned PW    = shpp_pkg::ProdW;
  localparam int unsigned RrW   = shpp_pkg::RrW;
  localparam int unsigned BitW  = shpp_pkg::RrBitW;

  shpp_pkg::back_state_e state_q, state_d;
  shpp_pkg::rec_t        cur_q, cur_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RrW-1:0]   rr_q, rr_d;
  logic [IdW-1:0]   least_id_q, least_id_d;
  logic [NW-1:0]    least_cnt_q, least_cnt_d;
  logic             least_valid_q, least_valid_d;
  logic [IdW-1:0]   best_id_q, best_id_d;
  logic [NW-1:0]    best_load_q, best_load_d;
  logic [WW-1:0]    best_weight_q, best_weight_d;
  logic             best_valid_q, best_valid_d;
  logic             ovf_q, ovf_d;
  logic [PW-1:0]    lhs_q, lhs_d;
  logic [PW-1:0]    rhs_q, rhs_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [IdW-1:0]   chosen_q, chosen_d;
  logic             out_ovf_q, out_ovf_d;

  logic [IdW-1:0]   buf_mem [MaxShards];
  logic [IdW-1:0]   rd_q;
  logic             buf_we;
  logic [WW-1:0]    mul_a, mul_b;
  logic [PW-1:0]    mul_p;
  logic [CntW:0]    rem_shift;
  logic [CntW:0]    rem_sub;
  logic             out_free;
  logic             clear_run;

  // output register frees up when empty or taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // shared multiplier for the cross products
  always_comb begin
    if (state_q == shpp_pkg::BK_MUL_L) begin
      mul_a = cur_q.count;
      mul_b = best_weight_q;
    end else begin
      mul_a = best_load_q;
      mul_b = cur_q.weight;
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // one restoring step of rr_position mod healthy count
  assign rem_shift = {rem_q, rr_q[bit_q]};
  assign rem_sub   = rem_shift - {1'b0, cnt_q};

  assign pop_ready_o = (state_q == shpp_pkg::BK_IDLE);

  // next state and datapath
  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    cnt_d         = cnt_q;
    rr_d          = rr_q;
    least_id_d    = least_id_q;
    least_cnt_d   = least_cnt_q;
    least_valid_d = least_valid_q;
    best_id_d     = best_id_q;
    best_load_d   = best_load_q;
    best_weight_d = best_weight_q;
    best_valid_d  = best_valid_q;
    ovf_d         = ovf_q;
    lhs_d         = lhs_q;
    rhs_d         = rhs_q;
    rem_d         = rem_q;
    bit_d         = bit_q;
    out_valid_d   = out_valid_q && out_stall_i;
    found_d       = found_q;
    chosen_d      = chosen_q;
    out_ovf_d     = out_ovf_q;
    buf_we        = 1'b0;
    clear_run     = 1'b0;

    unique case (state_q)
      shpp_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          cur_d = pop_data_i;
          if (pop_data_i.healthy) begin
            state_d = shpp_pkg::BK_MUL_L;
          end else if (pop_data_i.last) begin
            state_d = shpp_pkg::BK_END;
          end
        end
      end
      shpp_pkg::BK_MUL_L: begin
        lhs_d = mul_p;
        // buffer the id for round robin
        if (cnt_q < CntW'(MaxShards)) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        // least graph count candidate
        if (!least_valid_q || (cur_q.count < least_cnt_q) ||
            ((cur_q.count == least_cnt_q) && (cur_q.id < least_id_q))) begin
          least_valid_d = 1'b1;
          least_cnt_d   = cur_q.count;
          least_id_d    = cur_q.id;
        end
        state_d = shpp_pkg::BK_MUL_R;
      end
      shpp_pkg::BK_MUL_R: begin
        rhs_d   = mul_p;
        state_d = shpp_pkg::BK_CMP;
      end
      shpp_pkg::BK_CMP: begin
        // weighted candidate by cross multiplication
        if (!best_valid_q || (lhs_q < rhs_q) ||
            ((lhs_q == rhs_q) && (cur_q.id < best_id_q))) begin
          best_valid_d  = 1'b1;
          best_id_d     = cur_q.id;
          best_load_d   = cur_q.count;
          best_weight_d = cur_q.weight;
        end
        state_d = cur_q.last ? shpp_pkg::BK_END : shpp_pkg::BK_IDLE;
      end
      shpp_pkg::BK_END: begin
        if ((strategy_i == shpp_pkg::STRAT_ROUND_ROBIN) && (cnt_q != '0)) begin
          rem_d   = '0;
          bit_d   = BitW'(RrW - 1);
          state_d = shpp_pkg::BK_DIV;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_ovf_d   = ovf_q;
          case (strategy_i)
            shpp_pkg::STRAT_ROUND_ROBIN: begin
              found_d  = 1'b0;
              chosen_d = '0;
            end
            shpp_pkg::STRAT_WEIGHTED: begin
              found_d  = best_valid_q;
              chosen_d = best_valid_q ? best_id_q : '0;
            end
            default: begin
              found_d  = least_valid_q;
              chosen_d = least_valid_q ? least_id_q : '0;
            end
          endcase
          clear_run = 1'b1;
          state_d   = shpp_pkg::BK_IDLE;
        end
      end
      shpp_pkg::BK_DIV: begin
        if (!rem_sub[CntW]) begin
          rem_d = rem_sub[CntW-1:0];
        end else begin
          rem_d = rem_shift[CntW-1:0];
        end
        if (bit_q == '0) begin
          state_d = shpp_pkg::BK_READ;
        end else begin
          bit_d = bit_q - BitW'(1);
        end
      end
      shpp_pkg::BK_READ: begin
        state_d = shpp_pkg::BK_RR_OUT;
      end
      shpp_pkg::BK_RR_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          chosen_d    = rd_q;
          out_ovf_d   = ovf_q;
          rr_d        = rr_q + RrW'(1);
          clear_run   = 1'b1;
          state_d     = shpp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = shpp_pkg::BK_IDLE;
      end
    endcase

    // per request state returns to its starting values
    if (clear_run) begin
      cnt_d         = '0;
      least_id_d    = '0;
      least_cnt_d   = '0;
      least_valid_d = 1'b0;
      best_id_d     = '0;
      best_load_d   = '0;
      best_weight_d = WW'(1);
      best_valid_d  = 1'b0;
      ovf_d         = 1'b0;
    end
  end

  // control and candidate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= shpp_pkg::BK_IDLE;
      cnt_q         <= '0;
      rr_q          <= '0;
      least_id_q    <= '0;
      least_cnt_q   <= '0;
      least_valid_q <= 1'b0;
      best_id_q     <= '0;
      best_load_q   <= '0;
      best_weight_q <= WW'(1);
      best_valid_q  <= 1'b0;
      ovf_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      rem_q         <= '0;
      bit_q         <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      rr_q          <= rr_d;
      least_id_q    <= least_id_d;
      least_cnt_q   <= least_cnt_d;
      least_valid_q <= least_valid_d;
      best_id_q     <= best_id_d;
      best_load_q   <= best_load_d;
      best_weight_q <= best_weight_d;
      best_valid_q  <= best_valid_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
      rem_q         <= rem_d;
      bit_q         <= bit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    lhs_q     <= lhs_d;
    rhs_q     <= rhs_d;
    found_q   <= found_d;
    chosen_q  <= chosen_d;
    out_ovf_q <= out_ovf_d;
  end

  // healthy id buffer, registered read at the remainder
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[cnt_q[AddrW-1:0]] <= cur_q.id;
    end
    rd_q <= buf_mem[rem_q[AddrW-1:0]];
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign chosen_shard_o = chosen_q;
  assign overflow_o     = out_ovf_q;

  // buffer fill never passes its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxShards))
    else $error("healthy count beyond buffer depth");

  // the remainder unit only runs with a non-empty buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shpp_pkg::BK_DIV) |-> (cnt_q != '0))
    else $error("remainder started with empty buffer");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == shpp_pkg::BK_DIV) && (bit_q != BitW'(RrW - 1))) |-> (rem_q < cnt_q))
    else $error("partial remainder out of range");

  // a round robin pick reads a written entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shpp_pkg::BK_RR_OUT) |-> (rem_q < cnt_q))
    else $error("round robin read beyond buffered entries");

endmodule

FILE: sv/healthy_shard_placement_picker_unit.sv
// ---------------------------------------------------------------------------
// healthy_shard_placement_picker_unit: picks a healthy shard for placement
// Top level with configuration registers, intake, queue and selection.
// ---------------------------------------------------------------------------
// Usage
//   A pick request is a run of shard records on the input channel, one per
//   item, closed by an item with last_i set. Each record is checked for
//   health (online, heartbeat present, age within heartbeat_timeout) as it
//   is accepted and queued; the back end takes non-healthy records in its
//   idle state and steps healthy ones through MUL_L, MUL_R and CMP, as the
//   shared multiplier forms the two weighted cross products in turn.
//   One result (found, chosen shard, overflow) leaves on the output channel
//   per request. For least count and weighted it is set from the tracked
//   candidates in the END state; for round robin it follows the 64 step bit
//   serial remainder over the 64 bit rotation position and the buffer read.
//   Input is taken while the two entry queue has room, also while a result
//   waits at the output; a stalled result holds in the output register and
//   the back end waits before producing the next one.
//   Configuration: index 0 strategy, index 1 heartbeat timeout; writes are
//   always ready and belong in idle periods. Reset clears all control state
//   and needs no clearing pass; strategy returns to round robin, the
//   timeout to 10000 ms and the rotation position to zero.
// ---------------------------------------------------------------------------
module healthy_shard_placement_picker_unit #(
  parameter int unsigned MaxShards = shpp_pkg::MaxShardsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [shpp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [shpp_pkg::CfgDataW-1:0]   cfg_data_i,
  // shard records
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            has_record_i,
  input  logic [shpp_pkg::IdW-1:0]        shard_id_i,
  input  logic                            is_online_i,
  input  logic                            has_heartbeat_i,
  input  logic [shpp_pkg::TimeW-1:0]      heartbeat_ms_i,
  input  logic [shpp_pkg::TimeW-1:0]      now_ms_i,
  input  logic [shpp_pkg::WeightW-1:0]    capacity_weight_i,
  input  logic [shpp_pkg::CountW-1:0]     graph_count_i,
  input  logic                            last_i,
  // pick results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [shpp_pkg::IdW-1:0]        chosen_shard_o,
  output logic                            overflow_o
);

  logic [1:0]     strategy_q;
  logic [31:0]    timeout_q;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  shpp_pkg::rec_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= shpp_pkg::STRAT_ROUND_ROBIN;
      timeout_q  <= shpp_pkg::TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        shpp_pkg::CFG_STRATEGY: strategy_q <= cfg_data_i[1:0];
        shpp_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // intake and health classification
  shpp_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .has_record_i      (has_record_i),
    .shard_id_i        (shard_id_i),
    .is_online_i       (is_online_i),
    .has_heartbeat_i   (has_heartbeat_i),
    .heartbeat_ms_i    (heartbeat_ms_i),
    .now_ms_i          (now_ms_i),
    .capacity_weight_i (capacity_weight_i),
    .graph_count_i     (graph_count_i),
    .last_i            (last_i),
    .timeout_i         (timeout_q),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_data_o       (push_data)
  );

  // decoupling queue
  shpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // selection back end
  shpp_back #(
    .MaxShards (MaxShards)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .strategy_i     (strategy_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .chosen_shard_o (chosen_shard_o),
    .overflow_o     (overflow_o)
  );

endmodule
